// ===== rtl/lmra_pkg.sv =====
// Shared types and constants for the lookahead min-reorder accumulator.
package lmra_pkg;

   localparam int unsigned VALUE_W     = 30;
   localparam int unsigned TOTAL_W     = 31;
   localparam int unsigned LOOKAHEAD_W = 6;

   // level is not added to once it reaches this; a larger emitted value still replaces it
   localparam logic [TOTAL_W-1:0] LEVEL_CAP = 31'd1000000000;

   // command broadcast to every cell of the sorted chain
   typedef enum logic [1:0] {
      OP_HOLD    = 2'd0,
      OP_INSERT  = 2'd1,
      OP_INS_EXT = 2'd2,
      OP_EXTRACT = 2'd3
   } cell_op_type;

   // what a cell shows its neighbors
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               valid;
      logic               ahead;  // broadcast value sorts ahead of this entry
   } cell_type;

   // beat from the chain to the accumulator stage
   typedef struct packed {
      logic               valid;
      logic [VALUE_W-1:0] value;
      logic               last;
   } emit_type;

endpackage

// ===== rtl/lmra_cell.sv =====
// One cell of the sorted chain: holds one entry, talks to its two neighbors.
module lmra_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  lmra_pkg::cell_op_type             op,
   input  logic [lmra_pkg::VALUE_W-1:0]      new_value,
   input  lmra_pkg::cell_type                prev_cell,
   input  lmra_pkg::cell_type                next_cell,
   output lmra_pkg::cell_type                this_cell
);

   logic [lmra_pkg::VALUE_W-1:0] value_ff, value_in;
   logic                         valid_ff, valid_in;
   logic                         ahead;

   assign ahead = valid_ff && (new_value < value_ff);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      unique case (op)
         lmra_pkg::OP_HOLD: begin
            value_in = value_ff;
         end
         lmra_pkg::OP_INSERT: begin
            // shift right past the new value, or take it
            if (prev_cell.ahead) begin
               value_in = prev_cell.value;
            end else if (ahead || !valid_ff) begin
               value_in = new_value;
            end
            valid_in = valid_ff | prev_cell.valid;
         end
         lmra_pkg::OP_INS_EXT: begin
            // insert and drop the head in one step: view shifted left by one
            if (!ahead) begin
               if (next_cell.ahead || !next_cell.valid) begin
                  value_in = new_value;
               end else begin
                  value_in = next_cell.value;
               end
            end
         end
         lmra_pkg::OP_EXTRACT: begin
            value_in = next_cell.value;
            valid_in = next_cell.valid;
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign this_cell.value = value_ff;
   assign this_cell.valid = valid_ff;
   assign this_cell.ahead = ahead;

endmodule

// ===== rtl/lmra_accum.sv =====
// Level / needed-total update per emitted value, with the result register.
module lmra_accum (
   input  logic                              clock,
   input  logic                              reset,
   input  lmra_pkg::emit_type                emit_beat,
   output logic                              emit_ready,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [lmra_pkg::VALUE_W-1:0]      out_min_value,
   output logic [lmra_pkg::TOTAL_W-1:0]      out_needed_total,
   output logic                              out_last
);

   logic [lmra_pkg::TOTAL_W-1:0] level_ff, level_in;
   logic [lmra_pkg::TOTAL_W-1:0] needed_ff, needed_in;
   logic                         out_valid_ff, out_valid_in;
   logic [lmra_pkg::VALUE_W-1:0] out_value_ff;
   logic [lmra_pkg::TOTAL_W-1:0] out_total_ff;
   logic                         out_last_ff;

   logic [lmra_pkg::TOTAL_W-1:0] e_wide;
   logic                         level_below;
   logic [lmra_pkg::TOTAL_W-1:0] total_next;
   logic [lmra_pkg::TOTAL_W-1:0] level_next;
   logic                         take;

   assign emit_ready = !out_valid_ff || out_ready;
   assign take       = emit_beat.valid && emit_ready;
   assign e_wide     = {1'b0, emit_beat.value};
   assign level_below = level_ff < e_wide;

   // both branches computed side by side, then selected
   always_comb begin
      if (level_below) begin
         total_next = needed_ff + e_wide - level_ff;
         level_next = (e_wide < lmra_pkg::LEVEL_CAP) ? (e_wide + e_wide) : e_wide;
      end else begin
         total_next = needed_ff;
         level_next = (level_ff < lmra_pkg::LEVEL_CAP) ? (level_ff + e_wide) : level_ff;
      end
   end

   always_comb begin
      level_in     = level_ff;
      needed_in    = needed_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && out_ready) begin
         out_valid_in = 1'b0;
      end
      if (take) begin
         out_valid_in = 1'b1;
         if (emit_beat.last) begin
            level_in  = '0;   // new stream starts clean
            needed_in = '0;
         end else begin
            level_in  = level_next;
            needed_in = total_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_value_ff <= emit_beat.value;
         out_total_ff <= total_next;
         out_last_ff  <= emit_beat.last;
      end
      if (reset) begin
         level_ff     <= '0;
         needed_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         level_ff     <= level_in;
         needed_ff    <= needed_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid        = out_valid_ff;
   assign out_min_value    = out_value_ff;
   assign out_needed_total = out_total_ff;
   assign out_last         = out_last_ff;

endmodule

// ===== rtl/lookahead_min_reorder_accumulator.sv =====
// Top level: sorted cell chain, emit stage and running-total accumulator.
// Each accepted beat is registered in the emit stage and then in the output register.
// Throughput: 1 beat per cycle while results are taken; the last beat starts a flush, if values
//   are held, that emits them one per cycle while results are taken, with no beat taken meanwhile.
// Rate is set by the sorted chain: one insert, extract or insert-and-extract per cycle.
// Reset (synchronous): chain empty, count, level, total and lookahead cleared; no sweep.
module lookahead_min_reorder_accumulator #(
   parameter int unsigned DEPTH = 63
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [lmra_pkg::VALUE_W-1:0]      req_value,
   input  logic                              req_last_in,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [lmra_pkg::VALUE_W-1:0]      rsp_min_value,
   output logic [lmra_pkg::TOTAL_W-1:0]      rsp_needed_total,
   output logic                              rsp_last_out,
   input  logic                              csr_wr_en,
   input  logic [lmra_pkg::LOOKAHEAD_W-1:0]  csr_wr_data
);

   localparam int unsigned CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_RUN   = 2'b01,
      ST_FLUSH = 2'b10
   } state_type;

   state_type                         state_ff, state_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [lmra_pkg::LOOKAHEAD_W-1:0]  lookahead_ff;
   logic [CW-1:0]                     look_eff;

   lmra_pkg::emit_type                emit_ff, emit_in;
   logic                              emit_ready;
   logic                              stage_free;
   logic                              accept;
   lmra_pkg::cell_op_type             op;

   lmra_pkg::cell_type                cells     [DEPTH];
   lmra_pkg::cell_type                cell_prev [DEPTH];
   lmra_pkg::cell_type                cell_next [DEPTH];
   logic [DEPTH-1:0]                  cell_vld;

   // ---------------------------------------------------------------
   // Lookahead register; values above the chain length act as DEPTH
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         lookahead_ff <= '0;
      end else if (csr_wr_en) begin
         lookahead_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (lookahead_ff > lmra_pkg::LOOKAHEAD_W'(DEPTH)) begin
         look_eff = CW'(DEPTH);
      end else begin
         look_eff = CW'(lookahead_ff);
      end
   end

   // ---------------------------------------------------------------
   // Sorted chain: cell 0 holds the smallest value, valid entries are
   // a prefix. Ends see a "minus infinity" on the left and an empty
   // slot on the right.
   // ---------------------------------------------------------------
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_lo
         assign cell_prev[i] = '{value: '0, valid: 1'b1, ahead: 1'b0};
      end else begin : g_mid_lo
         assign cell_prev[i] = cells[i-1];
      end
      if (i == DEPTH - 1) begin : g_hi
         assign cell_next[i] = '{value: '0, valid: 1'b0, ahead: 1'b0};
      end else begin : g_mid_hi
         assign cell_next[i] = cells[i+1];
      end

      lmra_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .op        (op),
         .new_value (req_value),
         .prev_cell (cell_prev[i]),
         .next_cell (cell_next[i]),
         .this_cell (cells[i])
      );

      assign cell_vld[i] = cells[i].valid;
   end

   // ---------------------------------------------------------------
   // Control: emit stage takes a beat when it is empty or draining
   // ---------------------------------------------------------------
   assign stage_free = !emit_ff.valid || emit_ready;
   assign req_ready  = (state_ff == ST_RUN) && stage_free;
   assign accept     = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      op       = lmra_pkg::OP_HOLD;
      emit_in  = emit_ff;
      if (emit_ff.valid && emit_ready) begin
         emit_in.valid = 1'b0;
      end
      unique case (state_ff)
         ST_RUN: begin
            if (accept) begin
               if (req_last_in || (count_ff >= look_eff)) begin
                  // insert and hand out the smallest of chain plus new value
                  op            = lmra_pkg::OP_INS_EXT;
                  emit_in.valid = 1'b1;
                  emit_in.value = (cells[0].ahead || !cells[0].valid) ?
                                  req_value : cells[0].value;
                  emit_in.last  = req_last_in && (count_ff == '0);
                  if (req_last_in && (count_ff != '0)) begin
                     state_in = ST_FLUSH;
                  end
               end else begin
                  op       = lmra_pkg::OP_INSERT;
                  count_in = count_ff + CW'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (stage_free) begin
               op            = lmra_pkg::OP_EXTRACT;
               emit_in.valid = 1'b1;
               emit_in.value = cells[0].value;
               emit_in.last  = (count_ff == CW'(1));
               count_in      = count_ff - CW'(1);
               if (count_ff == CW'(1)) begin
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      emit_ff.value <= emit_in.value;
      emit_ff.last  <= emit_in.last;
      if (reset) begin
         state_ff      <= ST_RUN;
         count_ff      <= '0;
         emit_ff.valid <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         emit_ff.valid <= emit_in.valid;
      end
   end

   // ---------------------------------------------------------------
   // Level / total update and result register
   // ---------------------------------------------------------------
   lmra_accum u_accum (
      .clock            (clock),
      .reset            (reset),
      .emit_beat        (emit_ff),
      .emit_ready       (emit_ready),
      .out_valid        (rsp_valid),
      .out_ready        (rsp_ready),
      .out_min_value    (rsp_min_value),
      .out_needed_total (rsp_needed_total),
      .out_last         (rsp_last_out)
   );

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // occupied cells always match the fill count
   a_count_matches_cells: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_vld) == int'(count_ff))
      else $error("chain occupancy differs from count");

   // a flush only runs with something left to emit
   a_flush_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> (count_ff != '0))
      else $error("flush with empty chain");

   // head of chain never larger than its neighbor
   if (DEPTH > 1) begin : g_sorted_chk
      a_head_sorted: assert property (@(posedge clock) disable iff (reset)
         cells[1].valid |-> (cells[0].value <= cells[1].value))
         else $error("chain head out of order");
   end

   // the last beat of a stream leaves the chain empty once its emission is staged
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (emit_ff.valid && emit_ff.last && $changed(emit_ff.value)) |-> (count_ff == '0))
      else $error("stream end with values still held");

endmodule
